// ===== hw/rtl/swsa_pkg.sv =====
// ----------------------------------------------------------------------------
// swsa_pkg: shared types and constants
// Field widths, configuration register indexes and the back-end state type.
// ----------------------------------------------------------------------------
package swsa_pkg;

	localparam int CFG_W     = 5;
	localparam int SCORE_W   = 8;
	localparam int SUM_W     = 12;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_CNT_W = $clog2(SUM_W);

	localparam logic [CFG_W-1:0] NUM_CLASSES_RST = CFG_W'(12);
	localparam logic [CFG_W-1:0] WINDOW_LEN_RST  = CFG_W'(3);

	localparam logic signed [SCORE_W-1:0] SCORE_MIN = -8'sd128;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 8'sd127;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_CLASSES = 2'd0,
		REG_WINDOW_LEN  = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CALC,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

// ===== hw/rtl/swsa_front.sv =====
// ----------------------------------------------------------------------------
// swsa_front: input acceptance and classification
// Tracks the class position and frame slot and tags each score for the back end.
// ----------------------------------------------------------------------------
module swsa_front #(
	parameter int MAX_CLASSES = 16,
	parameter int MAX_WINDOW  = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic [swsa_pkg::CFG_W-1:0]                            num_classes,
	input  logic [swsa_pkg::CFG_W-1:0]                            window_len,
	input  logic                                                  in_valid,
	input  logic                                                  accept_ok,
	input  logic signed [swsa_pkg::SCORE_W-1:0]                   class_score,
	output logic                                                  push,
	output logic signed [swsa_pkg::SCORE_W-1:0]                   e_score,
	output logic [$clog2(MAX_CLASSES)-1:0]                        e_cls,
	output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] e_slot,
	output logic                                                  e_last,
	output logic [$clog2(MAX_WINDOW+1)-1:0]                       e_nwin
);
	import swsa_pkg::*;

	localparam int CW  = $clog2(MAX_CLASSES);
	localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NWW = $clog2(MAX_WINDOW+1);
	localparam int CCW = (CFG_W > $clog2(MAX_CLASSES+1)) ? CFG_W : $clog2(MAX_CLASSES+1);
	localparam int WCW = (CFG_W > NWW) ? CFG_W : NWW;

	logic [CW-1:0]  pos_q;
	logic [SW-1:0]  slot_q;
	logic [CCW-1:0] ncls;
	logic [WCW-1:0] nwin;
	logic [CW-1:0]  cls_c;
	logic [SW-1:0]  slot_c;
	logic           last_c;

	always_comb begin
		if (num_classes == '0) begin
			ncls = CCW'(1);
		end else if (CCW'(num_classes) > CCW'(MAX_CLASSES)) begin
			ncls = CCW'(MAX_CLASSES);
		end else begin
			ncls = CCW'(num_classes);
		end
		if (window_len == '0) begin
			nwin = WCW'(1);
		end else if (WCW'(window_len) > WCW'(MAX_WINDOW)) begin
			nwin = WCW'(MAX_WINDOW);
		end else begin
			nwin = WCW'(window_len);
		end
		cls_c  = (CCW'(pos_q) >= ncls) ? '0 : pos_q;
		slot_c = (WCW'(slot_q) >= nwin) ? '0 : slot_q;
		last_c = ((CCW'(cls_c) + CCW'(1)) == ncls);
	end

	assign push    = in_valid && accept_ok;
	assign e_score = class_score;
	assign e_cls   = cls_c;
	assign e_slot  = slot_c;
	assign e_last  = last_c;
	assign e_nwin  = nwin[NWW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			slot_q <= '0;
		end else if (push) begin
			if (last_c) begin
				pos_q  <= '0;
				slot_q <= ((WCW'(slot_c) + WCW'(1)) >= nwin) ? '0 : slot_c + SW'(1);
			end else begin
				pos_q  <= cls_c + CW'(1);
				slot_q <= slot_c;
			end
		end
	end

endmodule

// ===== hw/rtl/swsa_queue.sv =====
// ----------------------------------------------------------------------------
// swsa_queue: two-entry queue between front and back end
// Lets the front accept a score while the back end is still busy.
// ----------------------------------------------------------------------------
module swsa_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             nonempty
);
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign dout     = entry_q[rd_q];
	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= din;
		end
	end

endmodule

// ===== hw/rtl/swsa_back.sv =====
// ----------------------------------------------------------------------------
// swsa_back: history update, window mean and arg-max
// Updates history and running sums, divides by the window length one quotient
// bit per cycle and holds the result in the output register.
// ----------------------------------------------------------------------------
module swsa_back #(
	parameter int MAX_CLASSES = 16,
	parameter int MAX_WINDOW  = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  q_nonempty,
	output logic                                                  pop,
	input  logic signed [swsa_pkg::SCORE_W-1:0]                   h_score,
	input  logic [$clog2(MAX_CLASSES)-1:0]                        h_cls,
	input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] h_slot,
	input  logic                                                  h_last,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]                       h_nwin,
	output logic                                                  clear_done,
	output logic                                                  out_valid,
	input  logic                                                  out_ready,
	output logic signed [swsa_pkg::SCORE_W-1:0]                   averaged_score,
	output logic [swsa_pkg::IDX_W-1:0]                            class_index,
	output logic [swsa_pkg::IDX_W-1:0]                            top_class,
	output logic                                                  frame_end
);
	import swsa_pkg::*;

	localparam int CW  = $clog2(MAX_CLASSES);
	localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int AW  = CW + SW;
	localparam int NWW = $clog2(MAX_WINDOW+1);
	localparam int DW  = NWW + 1;

	bk_state_t state_q;
	bk_state_t state_d;

	logic signed [SCORE_W-1:0] hist_mem [2**AW];
	logic [SUM_W-1:0]          sum_mem  [2**CW];

	logic                      clr_busy_q;
	logic [AW-1:0]             clr_q;

	logic signed [SCORE_W-1:0] score_q;
	logic [CW-1:0]             cls_q;
	logic [SW-1:0]             slot_q;
	logic                      last_q;
	logic [NWW-1:0]            nwin_q;
	logic signed [SCORE_W-1:0] hist_rd_q;
	logic [SUM_W-1:0]          sum_rd_q;

	logic [SUM_W-1:0]          new_sum;
	logic [DW-1:0]             rem_q;
	logic [SUM_W-1:0]          dvd_q;
	logic                      neg_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic [DW-1:0]             trial;
	logic                      trial_ge;

	logic signed [SCORE_W-1:0] avg;
	logic signed [SCORE_W-1:0] best_q;
	logic [CW-1:0]             best_idx_q;
	logic                      better;
	logic [CW-1:0]             top_c;
	logic                      load_out;
	logic [CW+IDX_W-1:0]       cls_ext;
	logic [CW+IDX_W-1:0]       top_ext;

	logic                      out_valid_q;
	logic signed [SCORE_W-1:0] avg_q;
	logic [IDX_W-1:0]          cls_out_q;
	logic [IDX_W-1:0]          top_q;
	logic                      end_q;

	assign clear_done     = !clr_busy_q;
	assign out_valid      = out_valid_q;
	assign averaged_score = avg_q;
	assign class_index    = cls_out_q;
	assign top_class      = top_q;
	assign frame_end      = end_q;

	assign new_sum = sum_rd_q + {{(SUM_W-SCORE_W){score_q[SCORE_W-1]}}, score_q}
		- {{(SUM_W-SCORE_W){hist_rd_q[SCORE_W-1]}}, hist_rd_q};

	assign trial    = {rem_q[DW-2:0], dvd_q[SUM_W-1]};
	assign trial_ge = (trial >= {1'b0, nwin_q});

	always_comb begin
		if (!neg_q) begin
			avg = (dvd_q > SUM_W'(127)) ? SCORE_MAX : dvd_q[SCORE_W-1:0];
		end else begin
			avg = (dvd_q > SUM_W'(128)) ? SCORE_MIN : (~dvd_q[SCORE_W-1:0] + 8'd1);
		end
		better   = (avg > best_q);
		top_c    = better ? cls_q : best_idx_q;
		cls_ext  = {{IDX_W{1'b0}}, cls_q};
		top_ext  = {{IDX_W{1'b0}}, top_c};
		load_out = (state_q == BK_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_nonempty && !clr_busy_q) begin
					pop     = 1'b1;
					state_d = BK_CALC;
				end
			end
			BK_CALC: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (cnt_q == DIV_CNT_W'(SUM_W-1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (load_out) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == {AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			hist_mem[clr_q] <= '0;
		end else if (state_q == BK_CALC) begin
			hist_mem[{slot_q, cls_q}] <= score_q;
		end
		if (pop) begin
			hist_rd_q <= hist_mem[{h_slot, h_cls}];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			sum_mem[clr_q[CW-1:0]] <= '0;
		end else if (state_q == BK_CALC) begin
			sum_mem[cls_q] <= new_sum;
		end
		if (pop) begin
			sum_rd_q <= sum_mem[h_cls];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					score_q <= h_score;
					cls_q   <= h_cls;
					slot_q  <= h_slot;
					last_q  <= h_last;
					nwin_q  <= h_nwin;
				end
			end
			BK_CALC: begin
				rem_q <= '0;
				neg_q <= new_sum[SUM_W-1];
				dvd_q <= new_sum[SUM_W-1] ? (~new_sum + SUM_W'(1)) : new_sum;
				cnt_q <= '0;
			end
			BK_DIV: begin
				rem_q <= trial_ge ? (trial - {1'b0, nwin_q}) : trial;
				dvd_q <= {dvd_q[SUM_W-2:0], trial_ge};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= SCORE_MIN;
			best_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					best_q     <= SCORE_MIN;
					best_idx_q <= '0;
				end else if (better) begin
					best_q     <= avg;
					best_idx_q <= cls_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q     <= avg;
			cls_out_q <= cls_ext[IDX_W-1:0];
			top_q     <= last_q ? top_ext[IDX_W-1:0] : '0;
			end_q     <= last_q;
		end
	end

endmodule

// ===== hw/rtl/sliding_window_score_average_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_score_average_core: per-class moving average with arg-max
// Smooths classifier scores over the last frames and reports the best class.
// ----------------------------------------------------------------------------
// Scores enter on the in channel, one class per transfer in class order, and
// each produces one transfer on the out channel with the class's window mean,
// its class index and, on the last class of a frame, the winning class.
// The cfg channel writes num_classes (index 0) and window_len (index 1); it
// is always ready and should only be used while no score is in flight.
// An item passes through the back end as a memory read, the sum update and one
// quotient bit per cycle for twelve bits, then the output load. With the back
// end idle, out_valid rises once the score has gone through these steps, and the
// front queue holds two further scores while the back end is busy.
// After reset the history and sum memories are cleared, one entry per cycle,
// over 2**(clog2(MAX_CLASSES) + clog2(MAX_WINDOW)) entries (256 at defaults);
// in_ready stays low during that pass. A stalled out channel holds its result
// and the back end waits, so in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module sliding_window_score_average_core #(
	parameter int MAX_CLASSES = 16,
	parameter int MAX_WINDOW  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [swsa_pkg::SCORE_W-1:0]  class_score,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [swsa_pkg::SCORE_W-1:0]  averaged_score,
	output logic [swsa_pkg::IDX_W-1:0]           class_index,
	output logic [swsa_pkg::IDX_W-1:0]           top_class,
	output logic                                 frame_end,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swsa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swsa_pkg::CFG_W-1:0]           cfg_data
);
	import swsa_pkg::*;

	localparam int CW  = $clog2(MAX_CLASSES);
	localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NWW = $clog2(MAX_WINDOW+1);
	localparam int EW  = SCORE_W + CW + SW + 1 + NWW;

	logic [CFG_W-1:0]          num_classes_q;
	logic [CFG_W-1:0]          window_len_q;

	logic                      push;
	logic                      pop;
	logic                      q_full;
	logic                      q_nonempty;
	logic                      clear_done;
	logic [EW-1:0]             q_din;
	logic [EW-1:0]             q_dout;

	logic signed [SCORE_W-1:0] f_score;
	logic [CW-1:0]             f_cls;
	logic [SW-1:0]             f_slot;
	logic                      f_last;
	logic [NWW-1:0]            f_nwin;

	logic signed [SCORE_W-1:0] h_score;
	logic [CW-1:0]             h_cls;
	logic [SW-1:0]             h_slot;
	logic                      h_last;
	logic [NWW-1:0]            h_nwin;

	assign cfg_ready = 1'b1;
	assign in_ready  = clear_done && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NUM_CLASSES_RST;
			window_len_q  <= WINDOW_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NUM_CLASSES: begin
					num_classes_q <= cfg_data;
				end
				REG_WINDOW_LEN: begin
					window_len_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	swsa_front #(
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.num_classes (num_classes_q),
		.window_len  (window_len_q),
		.in_valid    (in_valid),
		.accept_ok   (in_ready),
		.class_score (class_score),
		.push        (push),
		.e_score     (f_score),
		.e_cls       (f_cls),
		.e_slot      (f_slot),
		.e_last      (f_last),
		.e_nwin      (f_nwin)
	);

	assign q_din = {f_score, f_cls, f_slot, f_last, f_nwin};
	assign {h_score, h_cls, h_slot, h_last, h_nwin} = q_dout;

	swsa_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (q_din),
		.pop      (pop),
		.dout     (q_dout),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	swsa_back #(
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_nonempty     (q_nonempty),
		.pop            (pop),
		.h_score        (h_score),
		.h_cls          (h_cls),
		.h_slot         (h_slot),
		.h_last         (h_last),
		.h_nwin         (h_nwin),
		.clear_done     (clear_done),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.averaged_score (averaged_score),
		.class_index    (class_index),
		.top_class      (top_class),
		.frame_end      (frame_end)
	);

endmodule
